### src/pkrl_pkg.sv
// Package for the per-key rate limiter: widths, register map and control structs.
`timescale 1ns / 1ps

package pkrl_pkg;

  // Table size used when the top level is not told otherwise.
  localparam int DEFAULT_TABLE_ENTRIES = 32;

  // Field widths.
  localparam int KEY_W      = 30;
  localparam int TIME_W     = 32;
  localparam int INTERVAL_W = 31;

  // Configuration port: one 32-bit register, word index taken from paddr[2].
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_MIN_INTERVAL = 1'b0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;      // take the input word and register the key match vector
    logic load_bypass;  // answer forward without touching the table
    logic lookup;       // encode matches and free entries, read the stored time
    logic commit;       // decide, update the table and load the result
  } pkrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic bypass;       // limiting off or no key present on the input word
  } pkrl_status_t;

endpackage

### src/pkrl_ctrl.sv
// Controller state machine of the per-key rate limiter.
`timescale 1ns / 1ps

module pkrl_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  pkrl_pkg::pkrl_status_t status,
  output pkrl_pkg::pkrl_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOOKUP = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;
  logic       slot_free;
  logic       accept;

  // The result register can take a new word when empty or being drained.
  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE) && slot_free;
  assign accept    = in_valid && in_ready;

  // Commands for the datapath.
  always_comb begin
    cmd.capture     = accept;
    cmd.load_bypass = accept && status.bypass;
    cmd.lookup      = (state == ST_LOOKUP);
    cmd.commit      = (state == ST_DECIDE) && slot_free;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && !status.bypass) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Result valid flag.
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_bypass || cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

### src/pkrl_dp.sv
// Datapath of the per-key rate limiter: key table, time memory, victim pointer, result.
`timescale 1ns / 1ps

module pkrl_dp #(
  parameter int TABLE_ENTRIES = pkrl_pkg::DEFAULT_TABLE_ENTRIES
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            key_valid,
  input  logic [pkrl_pkg::KEY_W-1:0]      station_key,
  input  logic [pkrl_pkg::TIME_W-1:0]     timestamp,
  input  logic [pkrl_pkg::INTERVAL_W-1:0] min_interval,
  input  pkrl_pkg::pkrl_cmd_t             cmd,
  output pkrl_pkg::pkrl_status_t          status,
  output logic                            forward
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  // Table storage: keys in flops for the parallel compare, times in a memory.
  logic [TABLE_ENTRIES-1:0]        used;
  logic [pkrl_pkg::KEY_W-1:0]      keys     [TABLE_ENTRIES];
  logic [pkrl_pkg::TIME_W-1:0]     time_mem [TABLE_ENTRIES];
  logic [IDX_W-1:0]                victim;

  // Item under work.
  logic [pkrl_pkg::KEY_W-1:0]      cur_key;
  logic [pkrl_pkg::TIME_W-1:0]     cur_time;
  logic [TABLE_ENTRIES-1:0]        match_vec;
  logic [TABLE_ENTRIES-1:0]        free_vec;
  logic                            hit;
  logic [IDX_W-1:0]                hit_idx;
  logic                            free_any;
  logic [IDX_W-1:0]                free_idx;
  logic [pkrl_pkg::TIME_W-1:0]     time_rd;

  // Encoder outputs.
  logic                            enc_hit;
  logic [IDX_W-1:0]                enc_hit_idx;
  logic                            enc_free;
  logic [IDX_W-1:0]                enc_free_idx;

  // Decision.
  logic [pkrl_pkg::TIME_W-1:0]     elapsed;
  logic                            suppress;
  logic                            refresh;
  logic [IDX_W-1:0]                wr_idx;
  logic                            insert;

  assign status.bypass = (min_interval == '0) || !key_valid;

  // Capture the word and compare its key against every used entry at once.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_key  <= station_key;
      cur_time <= timestamp;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        match_vec[i] <= used[i] && (keys[i] == station_key);
        free_vec[i]  <= !used[i];
      end
    end
  end

  // Lowest matching entry and lowest unused entry.
  always_comb begin
    enc_hit      = 1'b0;
    enc_hit_idx  = '0;
    enc_free     = 1'b0;
    enc_free_idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        enc_hit     = 1'b1;
        enc_hit_idx = IDX_W'(i);
      end
      if (free_vec[i]) begin
        enc_free     = 1'b1;
        enc_free_idx = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      hit      <= enc_hit;
      hit_idx  <= enc_hit_idx;
      free_any <= enc_free;
      free_idx <= enc_free_idx;
    end
  end

  // Elapsed time wraps modulo 2^32; a hit inside the interval is suppressed.
  assign elapsed  = cur_time - time_rd;
  assign suppress = hit && (elapsed < {1'b0, min_interval});
  assign refresh  = hit && !suppress;
  assign insert   = !hit;
  assign wr_idx   = hit ? hit_idx : (free_any ? free_idx : victim);

  // Time memory: registered read during lookup, one write at commit.
  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      time_rd <= time_mem[enc_hit_idx];
    end
    if (cmd.commit && (refresh || insert)) begin
      time_mem[wr_idx] <= cur_time;
    end
  end

  // Key store for new entries.
  always_ff @(posedge clk) begin
    if (cmd.commit && insert) begin
      keys[wr_idx] <= cur_key;
    end
  end

  // Used bits and the round-robin victim pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      used   <= '0;
      victim <= '0;
    end else if (cmd.commit && insert) begin
      used[wr_idx] <= 1'b1;
      if (!free_any) begin
        if (victim == IDX_W'(TABLE_ENTRIES - 1)) begin
          victim <= '0;
        end else begin
          victim <= victim + 1'b1;
        end
      end
    end
  end

  // Result word.
  always_ff @(posedge clk) begin
    if (cmd.load_bypass) begin
      forward <= 1'b1;
    end else if (cmd.commit) begin
      forward <= !suppress;
    end
  end

endmodule

### src/per_key_rate_limiter.sv
// Top level of the per-key rate limiter: configuration register, controller and datapath.
//
//   Channel  Direction  Handshake                  Word
//   in       input      in_valid / in_ready        key_valid, station_key, timestamp
//   out      output     out_valid / out_ready      forward
//   config   input      APB psel/penable/pready    min_interval at byte address 0
//
// A word that bypasses the table (limiting off or no key) is answered in the
// cycle after it is accepted. A table lookup goes in steps: key compare at
// accept, priority encode with the time memory read, then decide and write back.
// The single time memory port and the encode stage set these steps.
// Reset clears the used bits, the victim pointer and min_interval at once.
// A stalled result holds the block in its decide step; nothing is lost.
`timescale 1ns / 1ps

module per_key_rate_limiter #(
  parameter int TABLE_ENTRIES = pkrl_pkg::DEFAULT_TABLE_ENTRIES
) (
  input  logic                            clk,
  input  logic                            rst,
  // Request channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            key_valid,
  input  logic [pkrl_pkg::KEY_W-1:0]      station_key,
  input  logic [pkrl_pkg::TIME_W-1:0]     timestamp,
  // Result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            forward,
  // Configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pkrl_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [pkrl_pkg::APB_DATA_W-1:0] pwdata,
  output logic [pkrl_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  logic [pkrl_pkg::INTERVAL_W-1:0] min_interval;
  logic                            reg_index;
  pkrl_pkg::pkrl_cmd_t             cmd;
  pkrl_pkg::pkrl_status_t          status;

  // Configuration register.
  assign pready    = 1'b1;
  assign reg_index = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      min_interval <= '0;
    end else if (psel && penable && pwrite && pready &&
                 (reg_index == pkrl_pkg::REG_MIN_INTERVAL)) begin
      min_interval <= pwdata[pkrl_pkg::INTERVAL_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_index == pkrl_pkg::REG_MIN_INTERVAL) begin
      prdata = {{(pkrl_pkg::APB_DATA_W - pkrl_pkg::INTERVAL_W){1'b0}}, min_interval};
    end
  end

  pkrl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  pkrl_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .key_valid    (key_valid),
    .station_key  (station_key),
    .timestamp    (timestamp),
    .min_interval (min_interval),
    .cmd          (cmd),
    .status       (status),
    .forward      (forward)
  );

  // A bypassed word is answered with forward in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && ((min_interval == '0) || !key_valid))
      |=> (out_valid && forward))
    else $error("bypassed word not forwarded in the next cycle");

  // A table lookup keeps the input closed for its encode and decide steps.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (min_interval != '0) && key_valid)
      |=> (!in_ready ##1 !in_ready))
    else $error("input reopened during a table lookup");

  // The datapath only commits while the result register is empty or being drained.
  assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("result overwritten before it was taken");

endmodule

### tb/sv/per_key_rate_limiter_tb.sv
// Testbench for the per-key rate limiter: directed table, then random traffic checked by a predictor.
`timescale 1ns / 1ps

module per_key_rate_limiter_tb;
  import pkrl_pkg::*;

  localparam int ENTRIES       = DEFAULT_TABLE_ENTRIES;
  localparam int IDLE_LIMIT    = 4000;
  localparam int HOLD_CYCLES   = 150;
  localparam int TAIL_CYCLES   = 12;
  localparam int PHASES        = 10;
  localparam int PHASE_WORDS   = 200;
  localparam int DIRECTED_ROWS = 24;
  localparam logic [APB_ADDR_W-1:0] INTERVAL_ADDR = {REG_MIN_INTERVAL, 2'b00};
  localparam logic [KEY_W-1:0]      KEY_MAX       = {KEY_W{1'b1}};
  localparam int POOL_SIZES [PHASES] = '{4, 16, 33, 0, 48, 8, 32, 31, 64, 20};

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic                  key_valid;
  logic [KEY_W-1:0]      station_key;
  logic [TIME_W-1:0]     timestamp;
  logic                  out_valid;
  logic                  out_ready;
  logic                  forward;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  per_key_rate_limiter #(
    .TABLE_ENTRIES(ENTRIES)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .key_valid  (key_valid),
    .station_key(station_key),
    .timestamp  (timestamp),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .forward    (forward),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // One directed request; the interval is written first when it differs from the current one.
  typedef struct packed {
    logic [31:0]       interval;
    logic              key_valid;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] stamp;
    logic              has_fixed;
    logic              fwd;
  } request_row_t;

  request_row_t directed_rows [DIRECTED_ROWS] = '{
    // Limiting is off out of reset.
    '{32'd0, 1'b1, 30'd0, 32'd0, 1'b1, 1'b1},
    '{32'd0, 1'b1, KEY_MAX, 32'hFFFF_FFFF, 1'b1, 1'b1},
    // Key absent, then a new key, too soon twice, exactly the interval, backwards time.
    '{32'd10, 1'b0, 30'd5, 32'd0, 1'b1, 1'b1},
    '{32'd10, 1'b1, 30'd5, 32'd100, 1'b1, 1'b1},
    '{32'd10, 1'b1, 30'd5, 32'd105, 1'b1, 1'b0},
    '{32'd10, 1'b1, 30'd5, 32'd109, 1'b1, 1'b0},
    '{32'd10, 1'b1, 30'd5, 32'd110, 1'b1, 1'b1},
    '{32'd10, 1'b0, 30'd5, 32'd111, 1'b1, 1'b1},
    '{32'd10, 1'b1, 30'd5, 32'd50, 1'b1, 1'b1},
    // Elapsed time across the counter wrap.
    '{32'd10, 1'b1, 30'd0, 32'hFFFF_FFFA, 1'b1, 1'b1},
    '{32'd10, 1'b1, 30'd0, 32'd3, 1'b1, 1'b0},
    '{32'd10, 1'b1, 30'd0, 32'd4, 1'b1, 1'b1},
    '{32'd10, 1'b1, KEY_MAX, 32'd0, 1'b1, 1'b1},
    // Largest interval, written with the unused top bit set.
    '{32'hFFFF_FFFF, 1'b1, KEY_MAX, 32'h7FFF_FFFE, 1'b1, 1'b0},
    '{32'hFFFF_FFFF, 1'b1, KEY_MAX, 32'h7FFF_FFFF, 1'b1, 1'b1},
    '{32'hFFFF_FFFF, 1'b1, KEY_MAX, 32'h8000_0000, 1'b1, 1'b0},
    // Smallest nonzero interval.
    '{32'd1, 1'b1, 30'd5, 32'd50, 1'b1, 1'b0},
    '{32'd1, 1'b1, 30'd5, 32'd51, 1'b1, 1'b1},
    '{32'd1, 1'b1, 30'd0, 32'd4, 1'b1, 1'b0},
    // Disabling leaves the table untouched.
    '{32'd0, 1'b1, 30'd5, 32'd51, 1'b1, 1'b1},
    '{32'd1, 1'b1, 30'd5, 32'd51, 1'b1, 1'b0},
    '{32'd1, 1'b0, 30'd5, 32'd51, 1'b1, 1'b1},
    '{32'd1, 1'b1, KEY_MAX, 32'h8000_0005, 1'b0, 1'b0},
    '{32'd1, 1'b1, 30'h2AAA_AAAA, 32'h5555_5555, 1'b0, 1'b0}
  };

  // Predictor state: the lookup table, the victim pointer and the interval.
  bit                    entry_live    [ENTRIES];
  logic [KEY_W-1:0]      entry_station [ENTRIES];
  logic [TIME_W-1:0]     entry_stamp   [ENTRIES];
  int                    victim_ptr;
  logic [INTERVAL_W-1:0] interval_model;

  // Expected forward bits, oldest first.
  logic forward_due_q [$];
  logic due_fwd;

  int  mismatch_count;
  int  words_sent;
  int  results_seen;
  int  suppressed_seen;
  int  replacements;
  int  settings_written;
  int  burst_left = 20;
  int  idle_cycles;
  bit  hold_req;

  // Decide one request and update the predicted table the way the block should.
  function automatic bit decide_forward(input logic kv, input logic [KEY_W-1:0] key,
                                        input logic [TIME_W-1:0] stamp);
    int                slot;
    logic [TIME_W-1:0] elapsed;
    slot = -1;
    if (interval_model == '0 || !kv) return 1'b1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (entry_live[i] && entry_station[i] == key) begin
        elapsed = stamp - entry_stamp[i];
        if (elapsed < TIME_W'(interval_model)) return 1'b0;
        entry_stamp[i] = stamp;
        return 1'b1;
      end
      if (slot < 0 && !entry_live[i]) slot = i;
    end
    // Table full: take the round-robin victim.
    if (slot < 0) begin
      slot = victim_ptr;
      victim_ptr = (victim_ptr + 1) % ENTRIES;
      replacements++;
    end
    entry_live[slot]    = 1'b1;
    entry_station[slot] = key;
    entry_stamp[slot]   = stamp;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns, result %0d: %s", $time, results_seen, msg);
    mismatch_count++;
  endtask

  // Offer one word, wait for it to be taken, then record its expected result.
  task automatic send_request(input logic kv, input logic [KEY_W-1:0] key,
                              input logic [TIME_W-1:0] stamp,
                              input bit has_fixed, input bit fixed_fwd);
    bit fwd;
    in_valid    <= 1'b1;
    key_valid   <= kv;
    station_key <= key;
    timestamp   <= stamp;
    do @(posedge clk); while (!in_ready);
    fwd = decide_forward(kv, key, stamp);
    if (has_fixed) fwd = fixed_fwd;
    forward_due_q.push_back(fwd);
    words_sent++;
    // Bursts of random length with random gaps between them.
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
  endtask

  // Stop offering and wait until every expected result has come back.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (forward_due_q.size() != 0);
  endtask

  // Write the interval register, then read it back.
  task automatic apb_write_interval(input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= INTERVAL_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    interval_model = value[INTERVAL_W-1:0];
    settings_written++;
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[INTERVAL_W-1:0] !== interval_model)
      report_mismatch($sformatf("interval reads back %h, wrote %h",
                                prdata[INTERVAL_W-1:0], interval_model));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: random ready duty in stretches, plus one long hold-off on request.
  initial begin
    int pattern_left;
    int ready_pct;
    pattern_left = 0;
    ready_pct    = 100;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (pattern_left == 0) begin
          pattern_left = $urandom_range(16, 96);
          case ($urandom_range(0, 3))
            0: ready_pct = 100;
            1: ready_pct = 80;
            2: ready_pct = 50;
            default: ready_pct = 20;
          endcase
        end
        pattern_left--;
        out_ready <= ($urandom_range(1, 100) <= ready_pct);
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (forward_due_q.size() == 0) begin
        report_mismatch("result word with no request outstanding");
      end else begin
        due_fwd = forward_due_q.pop_front();
        if (forward !== due_fwd)
          report_mismatch($sformatf("forward is %b, predicted %b", forward, due_fwd));
        if (!due_fwd) suppressed_seen++;
      end
      results_seen++;
    end
  end

  // Watchdog: too long with no word moving on any port ends the run.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
      $display("FAIL per_key_rate_limiter");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus.
  initial begin
    request_row_t      row;
    logic [TIME_W-1:0] now_stamp;
    logic [TIME_W-1:0] step;
    logic [KEY_W-1:0]  key;
    logic [KEY_W-1:0]  key_pool [$];
    logic [31:0]       rnd;
    logic [31:0]       setting;
    logic              kv;
    longint            span;
    int                pool_size;

    idle_cycles    = 0;
    // The interval register comes out of reset as zero.
    interval_model = '0;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    key_valid   <= 1'b0;
    station_key <= '0;
    timestamp   <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part.
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      row = directed_rows[r];
      if (row.interval[INTERVAL_W-1:0] != interval_model) begin
        wait_results_drained();
        apb_write_interval(row.interval);
      end
      send_request(row.key_valid, row.key, row.stamp, row.has_fixed, row.fwd);
    end

    // Random phases: each picks an interval and a key pool, then sends a stream
    // whose time steps are scaled so that keys recur near the interval.
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_results_drained();
      case (ph)
        0: setting = 32'd1;
        1: setting = 32'd7;
        2: setting = 32'd0;
        3: setting = 32'd25;
        4: setting = 32'hFFFF_FFFF;
        5: setting = $urandom;
        6: setting = 32'd3;
        7: setting = 32'h8000_00C8;
        8: setting = 32'd1;
        default: setting = $urandom_range(2, 5000);
      endcase
      apb_write_interval(setting);

      pool_size = POOL_SIZES[ph];
      key_pool.delete();
      for (int k = 0; k < pool_size; k++) begin
        rnd = $urandom;
        key_pool.push_back(rnd[KEY_W-1:0]);
      end
      if (pool_size > 1 && ph % 2 == 0) key_pool[0] = '0;
      if (pool_size > 1 && ph % 3 == 0) key_pool[1] = KEY_MAX;

      if (ph % 3 == 0) now_stamp = 32'hFFFF_FFFF - $urandom_range(0, 1000);
      else now_stamp = $urandom;
      span = (2 * longint'(interval_model)) / ((pool_size > 0) ? pool_size : 1) + 1;
      if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;

      // Long receiver hold-off while words keep coming.
      if (ph == 1) hold_req = 1'b1;

      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (ph == 4 && n == PHASE_WORDS / 2) wait_results_drained();
        if ($urandom_range(0, 99) < 5) begin
          now_stamp = $urandom;
        end else begin
          step = $urandom_range(0, span[31:0]);
          now_stamp = now_stamp + step;
        end
        kv = ($urandom_range(0, 9) != 0);
        if (pool_size == 0 || $urandom_range(0, 29) == 0) begin
          rnd = $urandom;
          key = rnd[KEY_W-1:0];
        end else begin
          key = key_pool[$urandom_range(0, pool_size - 1)];
        end
        send_request(kv, key, now_stamp, 1'b0, 1'b0);
      end
    end

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d requests (%0d suppressed) over %0d interval settings,",
             words_sent, suppressed_seen, settings_written);
    $display("with %0d round-robin replacements in the key table.", replacements);
    if (mismatch_count == 0) begin
      $display("PASS per_key_rate_limiter");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("FAIL per_key_rate_limiter");
    end
    $finish;
  end

endmodule

### sim.f
src/pkrl_pkg.sv
src/pkrl_ctrl.sv
src/pkrl_dp.sv
src/per_key_rate_limiter.sv
tb/sv/per_key_rate_limiter_tb.sv
